// File: src/mqwf_pkg.sv
// ----------------------------------------------------------------------------
// mqwf_pkg
// shared constants and operation codes for the multi-queue work fifo
// ----------------------------------------------------------------------------
package mqwf_pkg;

    // default configuration
    localparam int DEFAULT_QUEUE_COUNT    = 16;
    localparam int DEFAULT_QUEUE_CAPACITY = 256;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 8;
    localparam int WORD_W  = 64;
    localparam int DEPTH_W = 9;
    localparam int TOTAL_W = 13;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_DEPTH = 2'd2,
        OP_TOTAL = 2'd3
    } op_t;

endpackage

// File: src/mqwf_state_mem.sv
// ----------------------------------------------------------------------------
// mqwf_state_mem
// per-queue state memory, registered read, entries read as zero
// until first written (valid flag per entry, cleared by reset)
// ----------------------------------------------------------------------------
module mqwf_state_mem #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 25,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: src/mqwf_entry_mem.sv
// ----------------------------------------------------------------------------
// mqwf_entry_mem
// work entry store, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module mqwf_entry_mem #(
    parameter int  DEPTH = 4096,
    parameter int  WIDTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/multi_queue_work_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_work_fifo
// per-processor ring queues of work entries (handler and argument words)
// a word runs through the state memory read, the decide and entry memory step and
//   the output load in order; a new word is taken only when the last one has
//   been loaded to the output, and a stalled output holds it back
// reset: control and running total cleared, per-queue state reads as zero
//   through valid flags at once, entry store is not cleared (no sweep)
// ----------------------------------------------------------------------------
module multi_queue_work_fifo
    import mqwf_pkg::*;
#(
    parameter int QUEUE_COUNT    = DEFAULT_QUEUE_COUNT,
    parameter int QUEUE_CAPACITY = DEFAULT_QUEUE_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    operation,
    input  logic [INDEX_W-1:0] queue_index,
    input  logic [INDEX_W-1:0] requester_index,
    input  logic [WORD_W-1:0]  work_handler,
    input  logic [WORD_W-1:0]  work_argument,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               success,
    output logic [WORD_W-1:0]  popped_handler,
    output logic [WORD_W-1:0]  popped_argument,
    output logic [DEPTH_W-1:0] queue_depth,
    output logic [TOTAL_W-1:0] total_depth,
    output logic               kick_request
);

    // derived widths
    localparam int QIDX_W    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int PTR_W     = $clog2(QUEUE_CAPACITY);
    localparam int CNT_W     = $clog2(QUEUE_CAPACITY + 1);
    localparam int ST_W      = 2 * PTR_W + CNT_W;
    localparam int ENT_DEPTH = QUEUE_COUNT * QUEUE_CAPACITY;
    localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

    // sequencer: read queue state, update and touch entry store, present result
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    state_t              state_reg,        state_next;
    op_t                 op_reg,           op_next;
    logic [QIDX_W-1:0]   qidx_reg,         qidx_next;
    logic                qvalid_reg,       qvalid_next;
    logic                other_reg,        other_next;
    logic [WORD_W-1:0]   handler_reg,      handler_next;
    logic [WORD_W-1:0]   argument_reg,     argument_next;
    logic [TOTAL_W-1:0]  total_reg,        total_next;
    logic                pop_ok_reg,       pop_ok_next;
    logic                res_ok_reg,       res_ok_next;
    logic                res_kick_reg,     res_kick_next;
    logic [DEPTH_W-1:0]  res_depth_reg,    res_depth_next;
    logic                out_valid_reg,    out_valid_next;
    logic                out_ok_reg,       out_ok_next;
    logic [WORD_W-1:0]   out_handler_reg,  out_handler_next;
    logic [WORD_W-1:0]   out_argument_reg, out_argument_next;
    logic [DEPTH_W-1:0]  out_depth_reg,    out_depth_next;
    logic [TOTAL_W-1:0]  out_total_reg,    out_total_next;
    logic                out_kick_reg,     out_kick_next;

    // queue state memory ports
    logic                st_rd_en;
    logic [ST_W-1:0]     st_rdata;
    logic                st_we;
    logic [ST_W-1:0]     st_wdata;
    logic [PTR_W-1:0]    st_rd_pos;
    logic [PTR_W-1:0]    st_wr_pos;
    logic [CNT_W-1:0]    st_cnt;

    // entry memory ports
    logic                ent_rd_en;
    logic                ent_we;
    logic [ENT_AW-1:0]   ent_addr;
    logic [2*WORD_W-1:0] ent_rdata;

    // per-item decisions in the exec step
    logic                in_accept;
    logic                out_free;
    logic                push_ok;
    logic                pop_ok;
    logic [PTR_W-1:0]    rd_pos_new;
    logic [PTR_W-1:0]    wr_pos_new;
    logic [CNT_W-1:0]    cnt_after;
    logic [PTR_W-1:0]    ent_pos;

    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // unpack stored queue state {read pos, write pos, count}
    assign st_rd_pos = st_rdata[ST_W-1 -: PTR_W];
    assign st_wr_pos = st_rdata[PTR_W+CNT_W-1 -: PTR_W];
    assign st_cnt    = st_rdata[CNT_W-1:0];

    // push needs a nonzero handler and room, pop needs an entry
    assign push_ok = (state_reg == ST_EXEC) && (op_reg == OP_PUSH) && qvalid_reg
                     && (handler_reg != '0) && (st_cnt < CNT_W'(QUEUE_CAPACITY));
    assign pop_ok  = (state_reg == ST_EXEC) && (op_reg == OP_POP) && qvalid_reg
                     && (st_cnt != '0);

    // ring positions wrap at the queue capacity
    assign rd_pos_new = (st_rd_pos == PTR_W'(QUEUE_CAPACITY - 1)) ? '0
                                                                   : st_rd_pos + 1'b1;
    assign wr_pos_new = (st_wr_pos == PTR_W'(QUEUE_CAPACITY - 1)) ? '0
                                                                   : st_wr_pos + 1'b1;

    always_comb
    begin
        priority if (push_ok)
        begin
            cnt_after = st_cnt + 1'b1;
            st_wdata  = {st_rd_pos, wr_pos_new, cnt_after};
        end
        else if (pop_ok)
        begin
            cnt_after = st_cnt - 1'b1;
            st_wdata  = {rd_pos_new, st_wr_pos, cnt_after};
        end
        else
        begin
            cnt_after = st_cnt;
            st_wdata  = st_rdata;
        end
    end

    assign st_rd_en  = in_accept;
    assign st_we     = push_ok || pop_ok;

    // entry slot: queue base plus ring position
    assign ent_pos   = pop_ok ? st_rd_pos : st_wr_pos;
    assign ent_addr  = ENT_AW'(ENT_AW'(qidx_reg) * ENT_AW'(QUEUE_CAPACITY))
                       + ENT_AW'(ent_pos);
    assign ent_we    = push_ok;
    assign ent_rd_en = pop_ok;

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        qidx_next         = qidx_reg;
        qvalid_next       = qvalid_reg;
        other_next        = other_reg;
        handler_next      = handler_reg;
        argument_next     = argument_reg;
        total_next        = total_reg;
        pop_ok_next       = pop_ok_reg;
        res_ok_next       = res_ok_reg;
        res_kick_next     = res_kick_reg;
        res_depth_next    = res_depth_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_ok_next       = out_ok_reg;
        out_handler_next  = out_handler_reg;
        out_argument_next = out_argument_reg;
        out_depth_next    = out_depth_reg;
        out_total_next    = out_total_reg;
        out_kick_next     = out_kick_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // capture the word, state memory read starts now
                    op_next       = op_t'(operation);
                    qidx_next     = QIDX_W'(queue_index);
                    qvalid_next   = {1'b0, queue_index} < (INDEX_W + 1)'(QUEUE_COUNT);
                    other_next    = queue_index != requester_index;
                    handler_next  = work_handler;
                    argument_next = work_argument;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // state data is here: decide, write back, touch entry store
                priority if (push_ok)
                begin
                    total_next = total_reg + 1'b1;
                end
                else if (pop_ok)
                begin
                    total_next = total_reg - 1'b1;
                end
                else
                begin
                    total_next = total_reg;
                end
                pop_ok_next    = pop_ok;
                res_ok_next    = ((op_reg != OP_PUSH) && (op_reg != OP_POP))
                                 || push_ok || pop_ok;
                res_kick_next  = push_ok && other_reg;
                res_depth_next = qvalid_reg ? DEPTH_W'(cnt_after) : '0;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                // popped entry is in the entry read register; wait for a free slot
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_ok_next       = res_ok_reg;
                    out_handler_next  = pop_ok_reg ? ent_rdata[2*WORD_W-1 -: WORD_W] : '0;
                    out_argument_next = pop_ok_reg ? ent_rdata[WORD_W-1:0] : '0;
                    out_depth_next    = res_depth_reg;
                    out_total_next    = total_reg;
                    out_kick_next     = res_kick_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_PUSH;
            qidx_reg         <= '0;
            qvalid_reg       <= 1'b0;
            other_reg        <= 1'b0;
            handler_reg      <= '0;
            argument_reg     <= '0;
            total_reg        <= '0;
            pop_ok_reg       <= 1'b0;
            res_ok_reg       <= 1'b0;
            res_kick_reg     <= 1'b0;
            res_depth_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_ok_reg       <= 1'b0;
            out_handler_reg  <= '0;
            out_argument_reg <= '0;
            out_depth_reg    <= '0;
            out_total_reg    <= '0;
            out_kick_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            qidx_reg         <= qidx_next;
            qvalid_reg       <= qvalid_next;
            other_reg        <= other_next;
            handler_reg      <= handler_next;
            argument_reg     <= argument_next;
            total_reg        <= total_next;
            pop_ok_reg       <= pop_ok_next;
            res_ok_reg       <= res_ok_next;
            res_kick_reg     <= res_kick_next;
            res_depth_reg    <= res_depth_next;
            out_valid_reg    <= out_valid_next;
            out_ok_reg       <= out_ok_next;
            out_handler_reg  <= out_handler_next;
            out_argument_reg <= out_argument_next;
            out_depth_reg    <= out_depth_next;
            out_total_reg    <= out_total_next;
            out_kick_reg     <= out_kick_next;
        end
    end

    // per-queue ring positions and counts
    mqwf_state_mem #(
        .DEPTH (QUEUE_COUNT),
        .WIDTH (ST_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (QIDX_W'(queue_index)),
        .rd_data (st_rdata),
        .wr_en   (st_we),
        .wr_addr (qidx_reg),
        .wr_data (st_wdata)
    );

    // handler and argument words, one slot per queue position
    mqwf_entry_mem #(
        .DEPTH (ENT_DEPTH),
        .WIDTH (2 * WORD_W)
    ) u_entry_mem (
        .clk     (clk),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_addr),
        .rd_data (ent_rdata),
        .wr_en   (ent_we),
        .wr_addr (ent_addr),
        .wr_data ({handler_reg, argument_reg})
    );

    assign in_stall        = state_reg != ST_IDLE;
    assign out_valid       = out_valid_reg;
    assign success         = out_ok_reg;
    assign popped_handler  = out_handler_reg;
    assign popped_argument = out_argument_reg;
    assign queue_depth     = out_depth_reg;
    assign total_depth     = out_total_reg;
    assign kick_request    = out_kick_reg;

endmodule
